/* sv/assert_macros.svh */
// Assertion macros for the deframer RTL; the queue uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define BFD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define BFD_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define BFD_ASSERT(lbl, clk, rst, prop)
`define BFD_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

/* sv/bfd_pkg.sv */
// Types and constants of the binary frame deframer.
package bfd_pkg;

   localparam int HeaderBytes       = 24;
   localparam int LengthCountBits   = 28;
   localparam int PayloadLengthBits = 28;
   localparam int VersionBits       = 16;
   localparam int CsrIndexBits      = 2;
   localparam int CsrDataBits       = 28;
   localparam int QueueDepth        = 4;
   localparam int QueuePtrBits      = $clog2(QueueDepth);
   localparam int QueueCountBits    = $clog2(QueueDepth + 1);
   localparam int RspDataBits       = 120;

   localparam logic [31:0] CountMask = 32'((64'd1 << LengthCountBits) - 64'd1);
   localparam logic [VersionBits-1:0] VersionReset = 16'd1;
   localparam logic [CsrDataBits-1:0] LimitReset = 28'd134217728;

   localparam logic [CsrIndexBits-1:0] CSR_EXPECTED_VERSION = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_PAYLOAD_LIMIT    = 2'd1;

   localparam logic [7:0] MagicBytes [4] = '{8'h50, 8'h57, 8'h46, 8'h31};

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_STATUS  = 2'd2
   } item_kind_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_HDR_TRUNC   = 3'd1,
      ST_BAD_MAGIC   = 3'd2,
      ST_BAD_VERSION = 3'd3,
      ST_TOO_LARGE   = 3'd4,
      ST_PAY_TRUNC   = 3'd5,
      ST_TRAILING    = 3'd6
   } status_type;

   typedef struct packed {
      logic [15:0]                  msg_type;
      logic [31:0]                  req_ident;
      logic [31:0]                  frame_flags;
      logic [PayloadLengthBits-1:0] payload_length;
   } header_fields_type;

   // one queue entry holds all beats that a single input byte produces
   typedef struct packed {
      item_kind_type     first_kind;
      logic              add_status;
      logic [7:0]        data_byte;
      status_type        status;
      header_fields_type header;
   } queue_entry_type;

endpackage

/* sv/bfd_front.sv */
// Front end: header parse, payload count and status classification.
module bfd_front
   import bfd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    end_of_frame,
   input  logic                    csr_we,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_wdata,
   output logic                    push,
   output queue_entry_type         entry
);

   logic [4:0]                   hdr_pos_ff, hdr_pos_in;
   logic                         magic_ff, magic_in;
   logic [15:0]                  version_ff, version_in;
   logic [15:0]                  type_ff, type_in;
   logic [31:0]                  request_ff, request_in;
   logic [31:0]                  flags_ff, flags_in;
   logic [31:0]                  length_ff, length_in;
   logic [LengthCountBits-1:0]   left_ff, left_in;
   status_type                   sticky_ff, sticky_in;
   logic [VersionBits-1:0]       exp_version_ff;
   logic [CsrDataBits-1:0]       limit_ff;

   always_comb begin
      hdr_pos_in = hdr_pos_ff;
      magic_in   = magic_ff;
      version_in = version_ff;
      type_in    = type_ff;
      request_in = request_ff;
      flags_in   = flags_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      sticky_in  = sticky_ff;
      push       = 1'b0;
      entry.first_kind = KIND_STATUS;
      entry.add_status = 1'b0;
      entry.data_byte  = data_byte;
      entry.status     = ST_OK;
      entry.header.msg_type       = type_ff;
      entry.header.req_ident      = request_ff;
      entry.header.frame_flags    = flags_ff;
      entry.header.payload_length = length_ff[PayloadLengthBits-1:0];
      if (accept) begin
         if (sticky_ff != ST_OK) begin
            // dropping until end of frame
         end else if (hdr_pos_ff < 5'(HeaderBytes)) begin
            if (hdr_pos_ff < 5'd4) begin
               if (data_byte != MagicBytes[hdr_pos_ff[1:0]]) begin
                  magic_in = 1'b0;
               end
            end else if (hdr_pos_ff inside {[5'd4:5'd5]}) begin
               version_in = {data_byte, version_ff[15:8]};
            end else if (hdr_pos_ff inside {[5'd6:5'd7]}) begin
               type_in = {data_byte, type_ff[15:8]};
            end else if (hdr_pos_ff inside {[5'd8:5'd11]}) begin
               request_in = {data_byte, request_ff[31:8]};
            end else if (hdr_pos_ff inside {[5'd12:5'd15]}) begin
               flags_in = {data_byte, flags_ff[31:8]};
            end else if (hdr_pos_ff inside {[5'd16:5'd19]}) begin
               length_in = {data_byte, length_ff[31:8]};
            end
            hdr_pos_in = hdr_pos_ff + 5'd1;
            if (hdr_pos_ff == 5'(HeaderBytes - 1)) begin
               if (!magic_ff) begin
                  sticky_in = ST_BAD_MAGIC;
               end else if (version_ff != exp_version_ff) begin
                  sticky_in = ST_BAD_VERSION;
               end else if (length_ff > 32'(limit_ff) || length_ff > CountMask) begin
                  sticky_in = ST_TOO_LARGE;
               end else begin
                  push             = 1'b1;
                  entry.first_kind = KIND_HEADER;
                  left_in          = length_ff[LengthCountBits-1:0];
               end
            end else if (end_of_frame) begin
               sticky_in = ST_HDR_TRUNC;
            end
         end else if (left_ff != '0) begin
            push             = 1'b1;
            entry.first_kind = KIND_PAYLOAD;
            left_in          = left_ff - LengthCountBits'(1);
         end else begin
            sticky_in = ST_TRAILING;
         end
         if (end_of_frame) begin
            if (sticky_in != ST_OK) begin
               entry.status = sticky_in;
            end else if (left_in != '0) begin
               entry.status = ST_PAY_TRUNC;
            end else begin
               entry.status = ST_OK;
            end
            if (push) begin
               entry.add_status = 1'b1;
            end else begin
               entry.first_kind = KIND_STATUS;
            end
            push       = 1'b1;
            hdr_pos_in = 5'd0;
            magic_in   = 1'b1;
            left_in    = '0;
            sticky_in  = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff     <= 5'd0;
         magic_ff       <= 1'b1;
         left_ff        <= '0;
         sticky_ff      <= ST_OK;
         exp_version_ff <= VersionReset;
         limit_ff       <= LimitReset;
      end else begin
         hdr_pos_ff <= hdr_pos_in;
         magic_ff   <= magic_in;
         left_ff    <= left_in;
         sticky_ff  <= sticky_in;
         if (csr_we && csr_index == CSR_EXPECTED_VERSION) begin
            exp_version_ff <= csr_wdata[VersionBits-1:0];
         end
         if (csr_we && csr_index == CSR_PAYLOAD_LIMIT) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      version_ff <= version_in;
      type_ff    <= type_in;
      request_ff <= request_in;
      flags_ff   <= flags_in;
      length_ff  <= length_in;
   end

endmodule

/* sv/bfd_queue.sv */
// Short queue of classified entries between front and back end.
`include "assert_macros.svh"
module bfd_queue
   import bfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output queue_entry_type head,
   output logic            empty,
   output logic            full
);

   queue_entry_type            mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueueCountBits-1:0]  count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QueueCountBits'(QueueDepth));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0
                   : wr_ptr_ff + QueuePtrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0
                   : rd_ptr_ff + QueuePtrBits'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QueueCountBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QueueCountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `BFD_ASSERT_NEVER(a_no_push_full, clock, reset, push && full)
   `BFD_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && empty)
   `BFD_ASSERT(a_count_up, clock, reset, push && !pop |=> count_ff > $past(count_ff))
   `BFD_ASSERT_NEVER(a_count_range, clock, reset, count_ff > QueueCountBits'(QueueDepth))

endmodule

/* sv/bfd_back.sv */
// Back end: expands queue entries into result beats behind an output register.
module bfd_back
   import bfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  queue_entry_type        head,
   input  logic                   empty,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   logic                   valid_ff, valid_in;
   logic                   phase_ff, phase_in;
   logic [RspDataBits-1:0] data_ff, data_in;
   item_kind_type          kind_ff, kind_in;
   logic                   last_ff, last_in;
   logic                   load;
   header_fields_type      hdr;
   logic [7:0]             pbyte;
   status_type             st;

   assign load = !empty && (!valid_ff || rsp_tready);

   always_comb begin
      kind_in = phase_ff ? KIND_STATUS : head.first_kind;
      last_in = phase_ff || !head.add_status;
      hdr     = '0;
      pbyte   = 8'd0;
      st      = ST_OK;
      case (kind_in)
         KIND_HEADER:  hdr   = head.header;
         KIND_PAYLOAD: pbyte = head.data_byte;
         KIND_STATUS:  st    = head.status;
         default:      st    = ST_OK;
      endcase
      data_in = {1'b0, st, pbyte, hdr.payload_length, hdr.frame_flags,
                 hdr.req_ident, hdr.msg_type};
      pop      = load && last_in;
      phase_in = phase_ff;
      valid_in = valid_ff;
      if (load) begin
         phase_in = !last_in;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         kind_ff <= kind_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* sv/binary_frame_deframer.sv */
// Binary frame deframer top level.
// Takes one byte beat per cycle while the queue is not full; each result beat passes
// the queue and the output register. Bytes at the header end or frame end may yield two
// beats, output one per cycle while the sink is ready, so the 4-entry queue between
// parser and output stage absorbs them. Synchronous active-high reset clears frame
// state and loads version 1 and payload limit 2^27; no clearing pass is needed.
module binary_frame_deframer
   import bfd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,  // data_byte[7:0]
   input  logic                    req_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // msg_type[15:0], req_ident[47:16], frame_flags[79:48],
   // payload_length[107:80], payload_byte[115:108], status[118:116], pad[119]
   output logic [RspDataBits-1:0]  rsp_tdata,
   output logic [1:0]              rsp_tuser,  // item_kind[1:0]
   output logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_wdata
);

   logic            accept;
   logic            push;
   logic            pop;
   logic            empty;
   logic            full;
   queue_entry_type push_entry;
   queue_entry_type head;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   bfd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_tdata),
      .end_of_frame (req_tlast),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push         (push),
      .entry        (push_entry)
   );

   bfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   bfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* verif/binary_frame_deframer_test.sv */
// Self-checking testbench for the binary frame deframer: directed and random frames, scoreboard.
`timescale 1ns / 1ps

module binary_frame_deframer_test;
   import bfd_pkg::*;

   localparam logic [CsrIndexBits-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CsrIndexBits-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [CsrDataBits-1:0]  LimitMax    = 28'hFFF_FFFF;

   typedef struct {
      logic [1:0]                   kind;
      logic [15:0]                  mtype;
      logic [31:0]                  rid;
      logic [31:0]                  flags;
      logic [PayloadLengthBits-1:0] plen;
      logic [7:0]                   pbyte;
      logic [2:0]                   status;
      logic                         last;
   } deframer_beat_type;

   class frame_scoreboard;
      logic [VersionBits-1:0]     version_reg;
      logic [CsrDataBits-1:0]     limit_reg;
      int unsigned                hdr_index;
      bit                         magic_ok;
      logic [15:0]                ver_acc;
      logic [15:0]                type_acc;
      logic [31:0]                id_acc;
      logic [31:0]                flags_acc;
      logic [31:0]                len_acc;
      logic [LengthCountBits-1:0] bytes_to_go;
      status_type                 held_error;
      deframer_beat_type          awaited[$];
      int                         mismatches;

      function new();
         version_reg = VersionReset;
         limit_reg   = LimitReset;
         mismatches  = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         hdr_index   = 0;
         magic_ok    = 1'b1;
         ver_acc     = '0;
         type_acc    = '0;
         id_acc      = '0;
         flags_acc   = '0;
         len_acc     = '0;
         bytes_to_go = '0;
         held_error  = ST_OK;
      endfunction

      function void write_register(logic [CsrIndexBits-1:0] index,
                                   logic [CsrDataBits-1:0] value);
         if (index == CSR_EXPECTED_VERSION) begin
            version_reg = value[VersionBits-1:0];
         end else if (index == CSR_PAYLOAD_LIMIT) begin
            limit_reg = value;
         end
      endfunction

      // predicts the beats caused by one accepted input byte
      function void note_byte(logic [7:0] b, logic eof);
         deframer_beat_type beat;
         status_type        st;
         int                first;
         first = awaited.size();
         if (held_error == ST_OK) begin
            if (hdr_index < HeaderBytes) begin
               if (hdr_index < 4) begin
                  if (b != MagicBytes[hdr_index]) magic_ok = 1'b0;
               end else if (hdr_index < 6) begin
                  ver_acc[8*(hdr_index-4) +: 8] = b;
               end else if (hdr_index < 8) begin
                  type_acc[8*(hdr_index-6) +: 8] = b;
               end else if (hdr_index < 12) begin
                  id_acc[8*(hdr_index-8) +: 8] = b;
               end else if (hdr_index < 16) begin
                  flags_acc[8*(hdr_index-12) +: 8] = b;
               end else if (hdr_index < 20) begin
                  len_acc[8*(hdr_index-16) +: 8] = b;
               end
               hdr_index++;
               if (hdr_index == HeaderBytes) begin
                  if (!magic_ok) begin
                     held_error = ST_BAD_MAGIC;
                  end else if (ver_acc != version_reg) begin
                     held_error = ST_BAD_VERSION;
                  end else if (len_acc > {4'd0, limit_reg} || len_acc > CountMask) begin
                     held_error = ST_TOO_LARGE;
                  end else begin
                     beat       = '{default: '0};
                     beat.kind  = KIND_HEADER;
                     beat.mtype = type_acc;
                     beat.rid   = id_acc;
                     beat.flags = flags_acc;
                     beat.plen  = len_acc[PayloadLengthBits-1:0];
                     awaited.insert(awaited.size(), beat);
                     bytes_to_go = len_acc[LengthCountBits-1:0];
                  end
               end else if (eof) begin
                  held_error = ST_HDR_TRUNC;
               end
            end else if (bytes_to_go != 0) begin
               beat       = '{default: '0};
               beat.kind  = KIND_PAYLOAD;
               beat.pbyte = b;
               awaited.insert(awaited.size(), beat);
               bytes_to_go--;
            end else begin
               held_error = ST_TRAILING;
            end
         end
         if (eof) begin
            st = held_error;
            if (st == ST_OK) st = (bytes_to_go != 0) ? ST_PAY_TRUNC : ST_OK;
            beat        = '{default: '0};
            beat.kind   = KIND_STATUS;
            beat.status = st;
            awaited.insert(awaited.size(), beat);
            clear_frame();
         end
         if (awaited.size() > first) awaited[awaited.size()-1].last = 1'b1;
      endfunction

      function void check_beat(logic [1:0] kind, logic [RspDataBits-1:0] data, logic last);
         deframer_beat_type want;
         bit                bad;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: kind %0d data %h last %0d", kind, data, last);
            return;
         end
         want = awaited.pop_front();
         bad = (kind !== want.kind) || (data[15:0] !== want.mtype) ||
               (data[47:16] !== want.rid) || (data[79:48] !== want.flags) ||
               (data[107:80] !== want.plen) || (data[115:108] !== want.pbyte) ||
               (data[118:116] !== want.status) || (data[119] !== 1'b0) ||
               (last !== want.last);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("beat mismatch: expected kind %0d type %h id %h flags %h ",
                      want.kind, want.mtype, want.rid, want.flags);
               $display("len %h byte %h status %0d last %0d",
                        want.plen, want.pbyte, want.status, want.last);
               $write("               actual   kind %0d type %h id %h flags %h ",
                      kind, data[15:0], data[47:16], data[79:48]);
               $display("len %h byte %h status %0d last %0d pad %b",
                        data[107:80], data[115:108], data[118:116], last, data[119]);
            end
         end
      endfunction
   endclass

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataBits-1:0]  rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_we     = 1'b0;
   logic [CsrIndexBits-1:0] csr_index  = CSR_EXPECTED_VERSION;
   logic [CsrDataBits-1:0]  csr_wdata  = '0;

   frame_scoreboard sb = new();
   logic [7:0]      frame_buf[$];
   bit              idling = 1'b1;
   int              sent_bytes = 0;
   int              stall_left = 0;
   logic [15:0]     cur_version;
   logic [CsrDataBits-1:0] cur_limit;

   binary_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // sink stalls in randomly timed bursts while idling is set
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 5) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("binary_frame_deframer_test: errors");
      $finish;
   end

   function automatic void append_byte(logic [7:0] b);
      frame_buf.insert(frame_buf.size(), b);
   endfunction

   function automatic void build_header(logic [15:0] ver, logic [31:0] len, logic [15:0] mtype,
                                        logic [31:0] rid, logic [31:0] flags);
      frame_buf = {};
      for (int i = 0; i < 4; i++) append_byte(MagicBytes[i]);
      for (int i = 0; i < 2; i++) append_byte(ver[8*i +: 8]);
      for (int i = 0; i < 2; i++) append_byte(mtype[8*i +: 8]);
      for (int i = 0; i < 4; i++) append_byte(rid[8*i +: 8]);
      for (int i = 0; i < 4; i++) append_byte(flags[8*i +: 8]);
      for (int i = 0; i < 4; i++) append_byte(len[8*i +: 8]);
      for (int i = 0; i < 4; i++) append_byte(8'($urandom));
   endfunction

   function automatic void random_header(logic [15:0] ver, logic [31:0] len);
      build_header(ver, len, 16'($urandom), $urandom, $urandom);
   endfunction

   function automatic void add_payload(int count);
      for (int i = 0; i < count; i++) append_byte(8'($urandom));
   endfunction

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++) begin
         if (idling && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= frame_buf[i];
         req_tlast  <= (i == frame_buf.size() - 1);
         do @(posedge clock); while (!req_tready);
         sent_bytes++;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexBits-1:0] index, logic [CsrDataBits-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_register(index, value);
   endtask

   initial begin
      int          random_start;
      int          frames;
      int          pick;
      int          len;
      int          cut;
      logic [31:0] bad_len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset configuration, version 1, limit 2^27
      build_header(16'd1, 32'd0, 16'h0000, 32'h0, 32'h0);
      send_frame();
      build_header(16'd1, 32'd3, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      append_byte(8'h00);
      append_byte(8'hFF);
      append_byte(8'h5A);
      send_frame();
      frame_buf = {MagicBytes[0]};
      send_frame();
      // header cut at 23 bytes with a bad magic still reports truncation
      random_header(16'd1, 32'd0);
      frame_buf[1] ^= 8'h01;
      void'(frame_buf.pop_back());
      send_frame();
      // bad magic outranks bad version and oversize length
      for (int p = 0; p < 4; p++) begin
         random_header(16'd2, 32'hFFFF_FFFF);
         frame_buf[p] ^= 8'h80;
         add_payload(3);
         send_frame();
      end
      random_header(16'd2, 32'hFFFF_FFFF);
      send_frame();
      random_header(16'd1, 32'h0800_0001);
      add_payload(2);
      send_frame();
      random_header(16'd1, 32'h0800_0000);
      add_payload(2);
      send_frame();
      random_header(16'd1, 32'd5);
      add_payload(2);
      send_frame();
      random_header(16'd1, 32'd2);
      add_payload(5);
      send_frame();
      random_header(16'd1, 32'd4);
      send_frame();

      write_csr(CSR_EXPECTED_VERSION, 28'hFFF_FFFF);
      write_csr(CSR_PAYLOAD_LIMIT, LimitMax);
      random_header(16'hFFFF, 32'h0FFF_FFFF);
      add_payload(1);
      send_frame();
      random_header(16'hFFFF, 32'h1000_0000);
      send_frame();

      write_csr(CSR_EXPECTED_VERSION, '0);
      write_csr(CSR_PAYLOAD_LIMIT, '0);
      write_csr(CSR_SPARE_A, 28'($urandom));
      write_csr(CSR_SPARE_B, 28'($urandom));
      random_header(16'd0, 32'd0);
      send_frame();
      random_header(16'd0, 32'd1);
      add_payload(4);
      send_frame();

      // random frames, configuration changed every few frames
      random_start = sent_bytes;
      frames = 0;
      cur_version = '0;
      cur_limit = '0;
      while (sent_bytes - random_start < 960) begin
         if (frames % 6 == 0) begin
            idling = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
               0: cur_version = 16'h0000;
               1: cur_version = 16'hFFFF;
               2: cur_version = 16'd1;
               default: cur_version = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
               0: cur_limit = '0;
               1: cur_limit = 28'($urandom_range(1, 24));
               2: cur_limit = LimitReset;
               default: cur_limit = LimitMax;
            endcase
            write_csr(CSR_EXPECTED_VERSION, {12'($urandom), cur_version});
            write_csr(CSR_PAYLOAD_LIMIT, cur_limit);
         end
         if (sent_bytes - random_start > 760) idling = 1'b0;
         frames++;
         len = $urandom_range(0, (cur_limit < 16) ? int'(cur_limit) : 16);
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            random_header(cur_version, len);
            add_payload(len);
         end else if (pick == 6) begin
            random_header(cur_version, len);
            case ($urandom_range(0, 2))
               0: frame_buf[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
               1: begin
                  frame_buf[4] ^= 8'($urandom_range(1, 255));
                  frame_buf[5] ^= 8'($urandom);
               end
               default: begin
                  if ($urandom_range(0, 1) == 0)
                     bad_len = {4'd0, cur_limit} + 32'($urandom_range(1, 1000));
                  else
                     bad_len = 32'hF000_0000 | $urandom;
                  for (int i = 0; i < 4; i++) frame_buf[16+i] = bad_len[8*i +: 8];
               end
            endcase
            add_payload($urandom_range(0, 8));
         end else if (pick == 7) begin
            random_header(cur_version, len);
            add_payload(len);
            cut = $urandom_range(1, frame_buf.size() - 1);
            frame_buf = frame_buf[0:cut-1];
         end else if (pick == 8) begin
            random_header(cur_version, len);
            add_payload(len + $urandom_range(1, 6));
         end else begin
            frame_buf = {};
            add_payload($urandom_range(1, 40));
         end
         send_frame();
      end

      idling = 1'b0;
      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("binary_frame_deframer_test: clean");
      end else begin
         $display("binary_frame_deframer_test: errors");
      end
      $finish;
   end

endmodule
